/* design/page_framebuffer_pixel_engine_assert.svh */
// Assertion macros for the pixel engine checker.
// All macros sample on the rising edge of clk.
`ifndef PAGE_FRAMEBUFFER_PIXEL_ENGINE_ASSERT_SVH
`define PAGE_FRAMEBUFFER_PIXEL_ENGINE_ASSERT_SVH

// Checked only while out of reset.
`define PFPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, including during reset.
`define PFPE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/pfpe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pfpe_pkg;

  localparam int STORE_BYTES = 1024;
  localparam int ADDR_W      = 10;
  localparam int COL_W       = 4;   // glyph column counter, glyph word is 16 bits
  localparam int IDX_W       = 13;  // x + page * width, up to 255 + 31 * 256

  typedef logic [1:0] action_t;

  localparam action_t ACT_CLEAR = 2'd0;
  localparam action_t ACT_SET   = 2'd1;
  localparam action_t ACT_GLYPH = 2'd2;
  localparam action_t ACT_READ  = 2'd3;

  typedef logic [1:0] addr_sel_t;

  localparam addr_sel_t ADDR_CLR  = 2'd0;
  localparam addr_sel_t ADDR_PIX  = 2'd1;
  localparam addr_sel_t ADDR_BYTE = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic      load;      // capture input transaction
    logic      clr_step;  // write zero at sweep address, advance sweep
    logic      calc;      // register pixel address of current column
    logic      col_next;  // advance glyph column
    logic      pix_wr;    // write back byte with pixel bit set
    addr_sel_t addr_sel;
    logic      out_load;  // load result register
  } pfpe_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic pix_ok;
    logic col_last;
  } pfpe_stat_t;

endpackage

`default_nettype wire

/* design/pfpe_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none

interface pfpe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  x;
  logic [7:0]  y;
  logic [15:0] glyph_row;
  logic [9:0]  byte_index;

  modport source (output valid, action, x, y, glyph_row, byte_index, input ready);
  modport sink   (input valid, action, x, y, glyph_row, byte_index, output ready);
endinterface

interface pfpe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

`default_nettype wire

/* design/pfpe_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module pfpe_datapath #(
  parameter int WIDTH      = 128,
  parameter int HEIGHT     = 64,
  parameter int GLYPH_COLS = 12
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire pfpe_pkg::pfpe_cmd_t  cmd,
  output pfpe_pkg::pfpe_stat_t      stat,
  input  wire logic [1:0]           in_action,
  input  wire logic [7:0]           in_x,
  input  wire logic [7:0]           in_y,
  input  wire logic [15:0]          in_glyph_row,
  input  wire logic [9:0]           in_byte_index,
  output logic [7:0]                out_read_data
);
  import pfpe_pkg::*;

  localparam logic [8:0]       WIDTH_L  = 9'(WIDTH);
  localparam logic [8:0]       HEIGHT_L = 9'(HEIGHT);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(GLYPH_COLS - 1);
  localparam logic [COL_W-1:0] TOP_BIT  = COL_W'(GLYPH_COLS);
  localparam logic [IDX_W-1:0] STORE_L  = IDX_W'(STORE_BYTES);

  logic [7:0]        mem [STORE_BYTES];

  action_t           act_r;
  logic [7:0]        x_r;
  logic [7:0]        y_r;
  logic [15:0]       glyph_r;
  logic [ADDR_W-1:0] bidx_r;
  logic [IDX_W-1:0]  page_base_r;
  logic [COL_W-1:0]  col_r;
  logic [COL_W-1:0]  col_nxt;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic [ADDR_W-1:0] clr_cnt_nxt;
  logic [ADDR_W-1:0] addr_r;
  logic [7:0]        rdata_r;
  logic [7:0]        out_data_r;

  logic [7:0]        px;
  logic [COL_W-1:0]  bit_sel;
  logic              bit_on;
  logic [IDX_W-1:0]  idx;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we;
  logic [7:0]        mem_wdata;

  // current column, wraps at 256 before the frame test
  assign px      = x_r + {4'b0, col_r};
  assign bit_sel = TOP_BIT - col_r;
  assign bit_on  = (act_r == ACT_SET) || glyph_r[bit_sel];
  assign idx     = {5'b0, px} + page_base_r;

  assign stat.pix_ok   = bit_on && ({1'b0, px} < WIDTH_L) && ({1'b0, y_r} < HEIGHT_L) &&
                         (idx < STORE_L);
  assign stat.col_last = (act_r == ACT_SET) || (col_r == LAST_COL);
  assign stat.clr_last = &clr_cnt_r;

  always_comb begin
    case (cmd.addr_sel)
      ADDR_CLR:  mem_addr = clr_cnt_r;
      ADDR_PIX:  mem_addr = addr_r;
      ADDR_BYTE: mem_addr = bidx_r;
      default:   mem_addr = addr_r;
    endcase
  end

  assign mem_we    = cmd.clr_step || cmd.pix_wr;
  assign mem_wdata = cmd.pix_wr ? (rdata_r | (8'b1 << y_r[2:0])) : 8'b0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_r <= mem[mem_addr];
  end

  always_comb begin
    col_nxt = col_r;
    if (cmd.load) begin
      col_nxt = '0;
    end else if (cmd.col_next) begin
      col_nxt = col_r + 1'b1;
    end
    clr_cnt_nxt = cmd.clr_step ? clr_cnt_r + 1'b1 : clr_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      clr_cnt_r <= '0;
    end else begin
      col_r     <= col_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r       <= in_action;
      x_r         <= in_x;
      y_r         <= in_y;
      glyph_r     <= in_glyph_row;
      bidx_r      <= in_byte_index;
      page_base_r <= IDX_W'({8'b0, in_y[7:3]} * IDX_W'(WIDTH));
    end
    if (cmd.calc) begin
      addr_r <= idx[ADDR_W-1:0];
    end
    if (cmd.out_load) begin
      out_data_r <= (act_r == ACT_READ) ? rdata_r : 8'b0;
    end
  end

  assign out_read_data = out_data_r;

endmodule

`default_nettype wire

/* design/pfpe_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module pfpe_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic [1:0]           in_action,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output pfpe_pkg::pfpe_cmd_t       cmd,
  input  wire pfpe_pkg::pfpe_stat_t stat
);
  import pfpe_pkg::*;

  localparam logic [2:0] S_BOOT_CLR = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_ITEM_CLR = 3'd2;
  localparam logic [2:0] S_CALC     = 3'd3;
  localparam logic [2:0] S_PIX_RD   = 3'd4;
  localparam logic [2:0] S_PIX_WR   = 3'd5;
  localparam logic [2:0] S_BYTE_RD  = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.addr_sel = ADDR_PIX;
    case (state_r)
      S_BOOT_CLR, S_ITEM_CLR: begin
        cmd.addr_sel = ADDR_CLR;
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = (state_r == S_BOOT_CLR) ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_action)
            ACT_CLEAR: state_nxt = S_ITEM_CLR;
            ACT_SET:   state_nxt = S_CALC;
            ACT_GLYPH: state_nxt = S_CALC;
            ACT_READ:  state_nxt = S_BYTE_RD;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        if (stat.pix_ok) begin
          state_nxt = S_PIX_RD;
        end else if (stat.col_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.col_next = 1'b1;
        end
      end
      S_PIX_RD: begin
        state_nxt = S_PIX_WR;
      end
      S_PIX_WR: begin
        cmd.pix_wr = 1'b1;
        if (stat.col_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.col_next = 1'b1;
          state_nxt    = S_CALC;
        end
      end
      S_BYTE_RD: begin
        cmd.addr_sel = ADDR_BYTE;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        // keep reading the requested byte so a stalled read result stays intact
        cmd.addr_sel = ADDR_BYTE;
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_BOOT_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* design/page_framebuffer_pixel_engine.sv */
// Set pixel: address calc, store read, write-back. Read byte: a single store read.
// Glyph row: address calc per column, read and write-back if drawn. Clear: 1024-entry sweep.
// Throughput: one transaction in flight; single-port store gives one access per cycle.
// A new input is taken while the previous result waits in the output register.
// Reset (rst_n low, synchronous): control cleared, then a 1024-entry clearing pass
// zeroes the store with in_ready held low.
`timescale 1ns / 1ps
`default_nettype none

module page_framebuffer_pixel_engine #(
  parameter int WIDTH      = 128,
  parameter int HEIGHT     = 64,
  parameter int GLYPH_COLS = 12
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  pfpe_in_if.sink     in_ch,
  pfpe_out_if.source  out_ch
);
  import pfpe_pkg::*;

  // Controller walks the sequence of store accesses for each transaction;
  // the datapath owns the 1024 x 8 store, the item registers and counters.
  pfpe_cmd_t  cmd;
  pfpe_stat_t stat;

  pfpe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Pixel (x, y) is bit y%8 of byte x + (y/8)*WIDTH; the page base is
  // multiplied once at load, each column then needs only an add and compare.
  pfpe_datapath #(
    .WIDTH      (WIDTH),
    .HEIGHT     (HEIGHT),
    .GLYPH_COLS (GLYPH_COLS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_action     (in_ch.action),
    .in_x          (in_ch.x),
    .in_y          (in_ch.y),
    .in_glyph_row  (in_ch.glyph_row),
    .in_byte_index (in_ch.byte_index),
    .out_read_data (out_ch.read_data)
  );

endmodule

`default_nettype wire

/* design/pfpe_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "page_framebuffer_pixel_engine_assert.svh"

module pfpe_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] read_data
);

  // one transaction at a time: a taken input drops ready
  `PFPE_ASSERT(a_one_in_flight, (in_valid && in_ready) |=> !in_ready, "accepted while busy")

  // a pending result holds until taken
  `PFPE_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(read_data)), "result dropped")

  // store clearing pass follows reset
  `PFPE_ASSERT_ALWAYS(a_boot_clear, !rst_n |=> (!in_ready && !out_valid), "ready during clear")

endmodule

bind page_framebuffer_pixel_engine pfpe_checker u_pfpe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .read_data (out_ch.read_data)
);

`default_nettype wire
